>>> rtl/gmms_pkg.sv
// shared types for the group median, mean and deviation block
`default_nettype none

package gmms_pkg;

   // sequencer states of the top level
   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_MED_RDI,
      S_MED_LDI,
      S_MED_RDJ,
      S_MED_CMP,
      S_MUL,
      S_MEAN,
      S_MEAN_WAIT,
      S_VAR,
      S_VAR_WAIT,
      S_ROOT,
      S_ROOT_WAIT,
      S_FIN
   } gmms_state_type;

   // command to the shared divide / square root unit
   typedef struct packed {
      logic start;
      logic root;
   } gmms_cmd_type;

endpackage

`default_nettype wire

>>> rtl/gmms_divsqrt.sv
// shared iterative unit: restoring divide and digit-by-digit square root
`default_nettype none

module gmms_divsqrt
   import gmms_pkg::*;
#(
   parameter int NUM_W = 64,
   parameter int DIV_W = 14
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire gmms_cmd_type       cmd,
   input  wire logic [NUM_W-1:0]   num,
   input  wire logic [DIV_W-1:0]   divisor,
   output logic                    done,
   output logic [NUM_W-1:0]        result
);

   localparam int HALF_W = NUM_W / 2;
   localparam int REM_W  = (DIV_W > HALF_W + 1) ? DIV_W : HALF_W + 1;
   localparam int X_W    = REM_W + 2;
   localparam int CNT_W  = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0] res_ff, res_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             root_ff, root_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [X_W-1:0]   alu_a, alu_b;
   logic [X_W:0]     alu_diff;
   logic             alu_ok;

   // the one subtract-compare shared by both operations
   always_comb begin
      if (root_ff) begin
         alu_a = {rem_ff, num_ff[NUM_W-1 -: 2]};
         alu_b = X_W'({res_ff, 2'b01});
      end else begin
         alu_a = {1'b0, rem_ff, num_ff[NUM_W-1]};
         alu_b = X_W'(div_ff);
      end
      alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
      alu_ok   = !alu_diff[X_W];
   end

   always_comb begin
      num_in  = num_ff;
      res_in  = res_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      root_in = root_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         num_in  = num;
         div_in  = divisor;
         res_in  = '0;
         rem_in  = '0;
         root_in = cmd.root;
         cnt_in  = cmd.root ? CNT_W'(HALF_W) : CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = alu_ok ? alu_diff[REM_W-1:0] : alu_a[REM_W-1:0];
         res_in = {res_ff[NUM_W-2:0], alu_ok};
         num_in = root_ff ? {num_ff[NUM_W-3:0], 2'b00} : {num_ff[NUM_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      res_ff  <= res_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
      root_ff <= root_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

`default_nettype wire

>>> rtl/group_median_mean_stdev.sv
// top level: median, mean and sample standard deviation over one group of counts
`default_nettype none

// channel  dir  handshake            words
// req      in   req_valid/req_stall  count_value, has_value, last
// rsp      out  rsp_valid/rsp_stall  group_empty, median_halves, mean_q8, stdev_q8
//
// loading takes one word per cycle while req_stall is low; req_stall is high from the
// closing word until the result sits in the output register. closing a non-empty group
// runs rank counting over the value memory, then the mean divide, then (for more than one
// value) the variance divide and root, all through one shared divide / square root unit.
// reset is synchronous; a waiting result does not block loading of the next group.

module group_median_mean_stdev
   import gmms_pkg::*;
#(
   parameter int MAX_ITEMS  = 64,
   parameter int VALUE_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_count_value,
   input  wire logic        req_has_value,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_group_empty,
   output logic [16:0]      rsp_median_halves,
   output logic [23:0]      rsp_mean_q8,
   output logic [23:0]      rsp_stdev_q8
);

   // stored value width: the count port carries 16 bits at most
   localparam int SW     = (VALUE_BITS < 16) ? VALUE_BITS : 16;
   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int SUM_W  = SW + CNT_W;
   localparam int SQ_W   = 2 * SW + CNT_W;
   localparam int D_W    = SQ_W + CNT_W;
   localparam int DEN_W  = 2 * CNT_W;
   localparam int NUM_W  = D_W + 16 + ((D_W + 16) % 2);

   gmms_state_type state_ff, state_in;

   // group accumulators
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;

   // rank counting for the median
   logic [ADDR_W-1:0] i_ff, i_in;
   logic [ADDR_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0]  rank_ff, rank_in;
   logic [SW-1:0]     cand_ff, cand_in;
   logic [SW-1:0]     lo_ff, lo_in;
   logic [SW-1:0]     hi_ff, hi_in;

   // variance terms and results
   logic [D_W-1:0]    prod_a_ff, prod_a_in;
   logic [D_W-1:0]    prod_b_ff, prod_b_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [23:0]       mean_ff, mean_in;
   logic [23:0]       stdev_ff, stdev_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_empty_ff, rsp_empty_in;
   logic [16:0]       rsp_median_ff, rsp_median_in;
   logic [23:0]       rsp_mean_ff, rsp_mean_in;
   logic [23:0]       rsp_stdev_ff, rsp_stdev_in;

   // value memory
   logic [SW-1:0]     mem [MAX_ITEMS];
   logic [ADDR_W-1:0] rd_addr;
   logic [SW-1:0]     rdata_ff;

   logic              accept;
   logic              store_en;
   logic [SW-1:0]     v;
   logic [2*SW-1:0]   vsq;
   logic [CNT_W-1:0]  half;
   logic              less;
   logic [CNT_W-1:0]  rank_fin;
   logic [SW:0]       med_sum;

   gmms_cmd_type      unit_cmd;
   logic [NUM_W-1:0]  unit_num;
   logic [DEN_W-1:0]  unit_div;
   logic              unit_done;
   logic [NUM_W-1:0]  unit_res;

   gmms_divsqrt #(
      .NUM_W (NUM_W),
      .DIV_W (DEN_W)
   ) u_divsqrt (
      .clock   (clock),
      .reset   (reset),
      .cmd     (unit_cmd),
      .num     (unit_num),
      .divisor (unit_div),
      .done    (unit_done),
      .result  (unit_res)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign v         = SW'(req_count_value);
   assign vsq       = (2*SW)'(v) * (2*SW)'(v);
   assign store_en  = accept && req_has_value && (cnt_ff < CNT_W'(MAX_ITEMS));
   assign half      = cnt_ff >> 1;

   // rank of the candidate: smaller values, plus equal ones stored earlier
   assign less     = (rdata_ff < cand_ff) || ((rdata_ff == cand_ff) && (j_ff < i_ff));
   assign rank_fin = rank_ff + CNT_W'(less);
   assign med_sum  = {1'b0, hi_ff} + {1'b0, lo_ff};

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      sum_in        = sum_ff;
      sq_in         = sq_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      rank_in       = rank_ff;
      cand_in       = cand_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      prod_a_in     = prod_a_ff;
      prod_b_in     = prod_b_ff;
      den_in        = den_ff;
      mean_in       = mean_ff;
      stdev_in      = stdev_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_empty_in  = rsp_empty_ff;
      rsp_median_in = rsp_median_ff;
      rsp_mean_in   = rsp_mean_ff;
      rsp_stdev_in  = rsp_stdev_ff;
      rd_addr       = j_ff;
      unit_cmd      = '{start: 1'b0, root: 1'b0};
      unit_num      = NUM_W'({sum_ff, 8'h00});
      unit_div      = DEN_W'(cnt_ff);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (store_en) begin
                  cnt_in = cnt_ff + CNT_W'(1);
                  sum_in = sum_ff + SUM_W'(v);
                  sq_in  = sq_ff + SQ_W'(vsq);
               end
               if (req_last) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            i_in = '0;
            // an empty group goes straight to the result
            state_in = (cnt_ff == '0) ? S_FIN : S_MED_RDI;
         end
         S_MED_RDI: begin
            rd_addr  = i_ff;
            state_in = S_MED_LDI;
         end
         S_MED_LDI: begin
            cand_in  = rdata_ff;
            j_in     = '0;
            rank_in  = '0;
            state_in = S_MED_RDJ;
         end
         S_MED_RDJ: begin
            state_in = S_MED_CMP;
         end
         S_MED_CMP: begin
            if (CNT_W'(j_ff) == cnt_ff - CNT_W'(1)) begin
               if (rank_fin == half) begin
                  hi_in = cand_ff;
               end
               if (rank_fin == half - CNT_W'(1)) begin
                  lo_in = cand_ff;
               end
               if (CNT_W'(i_ff) == cnt_ff - CNT_W'(1)) begin
                  state_in = S_MUL;
               end else begin
                  i_in     = i_ff + ADDR_W'(1);
                  state_in = S_MED_RDI;
               end
            end else begin
               rank_in  = rank_fin;
               j_in     = j_ff + ADDR_W'(1);
               state_in = S_MED_RDJ;
            end
         end
         S_MUL: begin
            // n * sum of squares, sum squared, and n * (n - 1)
            prod_a_in = D_W'(cnt_ff) * D_W'(sq_ff);
            prod_b_in = D_W'(sum_ff) * D_W'(sum_ff);
            den_in    = DEN_W'(cnt_ff) * DEN_W'(cnt_ff - CNT_W'(1));
            state_in  = S_MEAN;
         end
         S_MEAN: begin
            unit_cmd = '{start: 1'b1, root: 1'b0};
            state_in = S_MEAN_WAIT;
         end
         S_MEAN_WAIT: begin
            if (unit_done) begin
               mean_in  = 24'(unit_res);
               stdev_in = '0;
               state_in = (cnt_ff == CNT_W'(1)) ? S_FIN : S_VAR;
            end
         end
         S_VAR: begin
            // variance scaled by 2^16 so the root carries eight fraction bits
            unit_num = NUM_W'({prod_a_ff - prod_b_ff, 16'h0000});
            unit_div = den_ff;
            unit_cmd = '{start: 1'b1, root: 1'b0};
            state_in = S_VAR_WAIT;
         end
         S_VAR_WAIT: begin
            if (unit_done) begin
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            unit_num = unit_res;
            unit_cmd = '{start: 1'b1, root: 1'b1};
            state_in = S_ROOT_WAIT;
         end
         S_ROOT_WAIT: begin
            if (unit_done) begin
               stdev_in = 24'(unit_res);
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // wait for a free output register, then clear the group
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_empty_in = (cnt_ff == '0);
               if (cnt_ff == '0) begin
                  rsp_median_in = '0;
                  rsp_mean_in   = '0;
                  rsp_stdev_in  = '0;
               end else begin
                  rsp_median_in = cnt_ff[0] ? 17'({hi_ff, 1'b0}) : 17'(med_sum);
                  rsp_mean_in   = mean_ff;
                  rsp_stdev_in  = stdev_ff;
               end
               cnt_in   = '0;
               sum_in   = '0;
               sq_in    = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff          <= i_in;
      j_ff          <= j_in;
      rank_ff       <= rank_in;
      cand_ff       <= cand_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      prod_a_ff     <= prod_a_in;
      prod_b_ff     <= prod_b_in;
      den_ff        <= den_in;
      mean_ff       <= mean_in;
      stdev_ff      <= stdev_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_median_ff <= rsp_median_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_stdev_ff  <= rsp_stdev_in;
   end

   // value memory: one write port at load, one registered read port
   always_ff @(posedge clock) begin
      if (store_en) begin
         mem[cnt_ff[ADDR_W-1:0]] <= v;
      end
      rdata_ff <= mem[rd_addr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_group_empty   = rsp_empty_ff;
   assign rsp_median_halves = rsp_median_ff;
   assign rsp_mean_q8       = rsp_mean_ff;
   assign rsp_stdev_q8      = rsp_stdev_ff;

endmodule

`default_nettype wire
